FILE: design/fbbi_pkg.sv
// shared types, constants and slot arithmetic for the fifo byte budget block index
// no dependencies; imported by fbbi_core, fbbi_rsp_reg and the top level

package fbbi_pkg;

   // table geometry and size bound
   localparam int MAX_ENTRIES     = 32;
   localparam int MAX_BLOCK_BYTES = 65536;

   localparam int SLOT_W  = $clog2(MAX_ENTRIES);
   localparam int CNT_W   = $clog2(MAX_ENTRIES + 1);
   localparam int OP_W    = 2;
   localparam int NUM_W   = 32;
   localparam int BYTES_W = 17;
   localparam int TOTAL_W = 40;
   localparam int KIND_W  = 3;

   localparam logic [TOTAL_W-1:0] LIMIT_RESET = TOTAL_W'(268435456);

   // operation codes
   localparam logic [OP_W-1:0] OP_NOTE  = 2'd0;
   localparam logic [OP_W-1:0] OP_QUERY = 2'd1;
   localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

   // result kinds
   localparam logic [KIND_W-1:0] K_EVICT   = 3'd0;
   localparam logic [KIND_W-1:0] K_ACCEPT  = 3'd1;
   localparam logic [KIND_W-1:0] K_SKIP    = 3'd2;
   localparam logic [KIND_W-1:0] K_REJECT  = 3'd3;
   localparam logic [KIND_W-1:0] K_HELD    = 3'd4;
   localparam logic [KIND_W-1:0] K_NOTHELD = 3'd5;
   localparam logic [KIND_W-1:0] K_CLEARED = 3'd6;

   typedef struct packed {
      logic [KIND_W-1:0]  kind;
      logic [NUM_W-1:0]   evicted_number;
      logic [TOTAL_W-1:0] total_bytes;
      logic               last;
   } rsp_type;

   typedef struct packed {
      logic               rd_en;
      logic [SLOT_W-1:0]  rd_addr;
      logic               wr_en;
      logic [SLOT_W-1:0]  wr_addr;
      logic [NUM_W-1:0]   wr_number;
      logic [BYTES_W-1:0] wr_bytes;
   } ram_ctl_type;

   // circular slot index: base plus offset, wrapped at the table depth
   function automatic logic [SLOT_W-1:0] slot_add(input logic [SLOT_W-1:0] base,
                                                  input logic [CNT_W-1:0]  off);
      logic [SLOT_W:0] sum;
      sum = {1'b0, base} + (SLOT_W+1)'(off);
      if (sum >= (SLOT_W+1)'(MAX_ENTRIES)) begin
         sum = sum - (SLOT_W+1)'(MAX_ENTRIES);
      end
      return sum[SLOT_W-1:0];
   endfunction

endpackage

FILE: design/fbbi_ram.sv
// generic single-write, single-read synchronous ram with registered read data
// no dependencies

module fbbi_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: design/fbbi_rsp_reg.sv
// one-deep output register between the sequencer and the result stream
// depends on fbbi_pkg for the result payload type

module fbbi_rsp_reg (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  fbbi_pkg::rsp_type in_data,
   output logic             out_valid,
   input  logic             out_ready,
   output fbbi_pkg::rsp_type out_data
);
   import fbbi_pkg::*;

   logic    valid_ff, valid_in;
   rsp_type data_ff, data_in;

   assign in_ready = !valid_ff || out_ready;

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (in_ready) begin
         valid_in = in_valid;
         if (in_valid) begin
            data_in = in_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      data_ff <= data_in;
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

FILE: design/fbbi_core.sv
// sequencer for the block index: membership scan, oldest-first eviction and append
// depends on fbbi_pkg; drives the two table rams through a control struct

module fbbi_core (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [fbbi_pkg::OP_W-1:0]     req_op,
   input  logic [fbbi_pkg::NUM_W-1:0]    req_number,
   input  logic [fbbi_pkg::BYTES_W-1:0]  req_bytes,
   input  logic                          csr_wr_en,
   input  logic [fbbi_pkg::TOTAL_W-1:0]  csr_wr_data,
   output fbbi_pkg::ram_ctl_type         ram_ctl,
   input  logic [fbbi_pkg::NUM_W-1:0]    rd_number,
   input  logic [fbbi_pkg::BYTES_W-1:0]  rd_bytes,
   output logic                          res_valid,
   input  logic                          res_ready,
   output fbbi_pkg::rsp_type             res_data
);
   import fbbi_pkg::*;

   localparam logic [2:0] ST_IDLE      = 3'd0;
   localparam logic [2:0] ST_SCAN      = 3'd1;
   localparam logic [2:0] ST_DECIDE    = 3'd2;
   localparam logic [2:0] ST_EVICT_RD  = 3'd3;
   localparam logic [2:0] ST_EVICT_OUT = 3'd4;
   localparam logic [2:0] ST_BUDGET    = 3'd5;
   localparam logic [2:0] ST_EMIT      = 3'd6;

   logic [2:0]         state_ff, state_in;
   logic [OP_W-1:0]    op_ff, op_in;
   logic [NUM_W-1:0]   number_ff, number_in;
   logic [BYTES_W-1:0] bytes_ff, bytes_in;
   logic               hit_ff, hit_in;
   logic [KIND_W-1:0]  kind_ff, kind_in;
   logic [TOTAL_W-1:0] limit_ff, limit_in;
   logic [SLOT_W-1:0]  oldest_ff, oldest_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [TOTAL_W-1:0] total_ff, total_in;
   logic [CNT_W-1:0]   idx_ff, idx_in;
   logic               pend_ff, pend_in;

   logic [TOTAL_W:0]   grown;
   logic               over;
   logic [TOTAL_W-1:0] drained;

   // budget check and saturating removal of the oldest entry's size
   assign grown   = {1'b0, total_ff} + (TOTAL_W+1)'(bytes_ff);
   assign over    = grown > {1'b0, limit_ff};
   assign drained = (total_ff >= TOTAL_W'(rd_bytes)) ? total_ff - TOTAL_W'(rd_bytes)
                                                     : '0;

   always_comb begin
      state_in  = state_ff;
      op_in     = op_ff;
      number_in = number_ff;
      bytes_in  = bytes_ff;
      hit_in    = hit_ff;
      kind_in   = kind_ff;
      limit_in  = csr_wr_en ? csr_wr_data : limit_ff;
      oldest_in = oldest_ff;
      count_in  = count_ff;
      total_in  = total_ff;
      idx_in    = idx_ff;
      pend_in   = pend_ff;

      req_ready = 1'b0;
      ram_ctl.rd_en     = 1'b0;
      ram_ctl.rd_addr   = oldest_ff;
      ram_ctl.wr_en     = 1'b0;
      ram_ctl.wr_addr   = slot_add(oldest_ff, count_ff);
      ram_ctl.wr_number = number_ff;
      ram_ctl.wr_bytes  = bytes_ff;

      res_valid = 1'b0;
      res_data.kind           = kind_ff;
      res_data.evicted_number = '0;
      res_data.total_bytes    = total_ff;
      res_data.last           = 1'b1;

      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               op_in     = req_op;
               number_in = req_number;
               bytes_in  = req_bytes;
               hit_in    = 1'b0;
               idx_in    = '0;
               pend_in   = 1'b0;
               case (req_op)
                  OP_NOTE, OP_QUERY: begin
                     state_in = (count_ff == '0) ? ST_DECIDE : ST_SCAN;
                  end
                  OP_CLEAR: begin
                     oldest_in = '0;
                     count_in  = '0;
                     total_in  = '0;
                     kind_in   = K_CLEARED;
                     state_in  = ST_EMIT;
                  end
                  default: begin
                     kind_in  = K_SKIP;
                     state_in = ST_EMIT;
                  end
               endcase
            end
         end
         ST_SCAN: begin
            // one read issued per cycle, compared the cycle after
            if (pend_ff && rd_number == number_ff) begin
               hit_in   = 1'b1;
               pend_in  = 1'b0;
               state_in = ST_DECIDE;
            end else begin
               if (idx_ff < count_ff) begin
                  ram_ctl.rd_en   = 1'b1;
                  ram_ctl.rd_addr = slot_add(oldest_ff, idx_ff);
                  idx_in          = idx_ff + 1'b1;
                  pend_in         = 1'b1;
               end else begin
                  pend_in = 1'b0;
               end
               if (pend_ff && idx_ff == count_ff) begin
                  state_in = ST_DECIDE;
               end
            end
         end
         ST_DECIDE: begin
            if (op_ff == OP_QUERY) begin
               kind_in  = hit_ff ? K_HELD : K_NOTHELD;
               state_in = ST_EMIT;
            end else if (bytes_ff == '0 || hit_ff) begin
               kind_in  = K_SKIP;
               state_in = ST_EMIT;
            end else if (32'(bytes_ff) > 32'(MAX_BLOCK_BYTES)) begin
               kind_in  = K_REJECT;
               state_in = ST_EMIT;
            end else if (count_ff >= CNT_W'(MAX_ENTRIES)) begin
               state_in = ST_EVICT_RD;
            end else begin
               state_in = ST_BUDGET;
            end
         end
         ST_EVICT_RD: begin
            ram_ctl.rd_en   = 1'b1;
            ram_ctl.rd_addr = oldest_ff;
            state_in        = ST_EVICT_OUT;
         end
         ST_EVICT_OUT: begin
            res_valid               = 1'b1;
            res_data.kind           = K_EVICT;
            res_data.evicted_number = rd_number;
            res_data.total_bytes    = drained;
            res_data.last           = 1'b0;
            if (res_ready) begin
               total_in  = drained;
               oldest_in = slot_add(oldest_ff, CNT_W'(1));
               count_in  = count_ff - 1'b1;
               state_in  = ST_BUDGET;
            end
         end
         ST_BUDGET: begin
            if (over && count_ff != '0) begin
               state_in = ST_EVICT_RD;
            end else begin
               res_valid = 1'b1;
               if (over) begin
                  res_data.kind = K_REJECT;
               end else begin
                  res_data.kind        = K_ACCEPT;
                  res_data.total_bytes = grown[TOTAL_W-1:0];
               end
               if (res_ready) begin
                  if (!over) begin
                     ram_ctl.wr_en = 1'b1;
                     count_in      = count_ff + 1'b1;
                     total_in      = grown[TOTAL_W-1:0];
                  end
                  state_in = ST_IDLE;
               end
            end
         end
         ST_EMIT: begin
            res_valid = 1'b1;
            if (res_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         limit_ff  <= LIMIT_RESET;
         oldest_ff <= '0;
         count_ff  <= '0;
         total_ff  <= '0;
         idx_ff    <= '0;
         pend_ff   <= 1'b0;
         hit_ff    <= 1'b0;
      end else begin
         state_ff  <= state_in;
         limit_ff  <= limit_in;
         oldest_ff <= oldest_in;
         count_ff  <= count_in;
         total_ff  <= total_in;
         idx_ff    <= idx_in;
         pend_ff   <= pend_in;
         hit_ff    <= hit_in;
      end
      op_ff     <= op_in;
      number_ff <= number_in;
      bytes_ff  <= bytes_in;
      kind_ff   <= kind_in;
   end

endmodule

FILE: design/fifo_byte_budget_block_index.sv
// top level of the fifo byte budget block index: streams, config register and table rams
// depends on fbbi_pkg, fbbi_ram, fbbi_core and fbbi_rsp_reg
//
//   channel   direction  ports                     content
//   req       in         req_tvalid/tready/tdata   tdata: block_number, block_bytes
//                        req_tuser                 tuser: operation
//   rsp       out        rsp_tvalid/tready/tdata   tdata: evicted_number, total_bytes
//                        rsp_tuser, rsp_tlast      tuser: kind; tlast: last result
//   csr       in         csr_wr_en, csr_wr_data    byte_limit, written when enable high
//
// one item at a time; a note or query first runs the membership scan, which reads one
// table entry per cycle through the ram port, is skipped on an empty table and
// ends early when the block is found
// the eviction for a full table adds a read of the oldest entry and a result transfer,
// each eviction for the budget adds a budget check, a read of the oldest entry and a transfer
// a clear or an unknown operation emits its result directly; results wait in a one-deep output
// register, so a stalled rsp side holds the sequencer on its pending result
// reset is synchronous; the tables need no clearing pass since only live entries are read

module fifo_byte_budget_block_index (
   input  logic        clock,
   input  logic        reset,
   // input stream
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [55:0] req_tdata,   // [31:0] block_number, [48:32] block_bytes, rest zero
   input  logic [1:0]  req_tuser,   // [1:0] operation
   // result stream
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [71:0] rsp_tdata,   // [31:0] evicted_number, [71:32] total_bytes
   output logic [2:0]  rsp_tuser,   // [2:0] kind
   output logic        rsp_tlast,
   // configuration
   input  logic        csr_wr_en,
   input  logic [39:0] csr_wr_data  // byte_limit
);
   import fbbi_pkg::*;

   // unpacked request fields
   logic [NUM_W-1:0]   req_number;
   logic [BYTES_W-1:0] req_bytes;

   assign req_number = req_tdata[NUM_W-1:0];
   assign req_bytes  = req_tdata[NUM_W+BYTES_W-1:NUM_W];

   // table ram control and read data
   ram_ctl_type        ram_ctl;
   logic [NUM_W-1:0]   rd_number;
   logic [BYTES_W-1:0] rd_bytes;

   // sequencer to output register
   logic    res_valid;
   logic    res_ready;
   rsp_type res_data;
   rsp_type out_data;

   // block numbers of stored entries, circular by arrival
   fbbi_ram #(
      .WIDTH (NUM_W),
      .DEPTH (MAX_ENTRIES)
   ) u_number_ram (
      .clock   (clock),
      .wr_en   (ram_ctl.wr_en),
      .wr_addr (ram_ctl.wr_addr),
      .wr_data (ram_ctl.wr_number),
      .rd_en   (ram_ctl.rd_en),
      .rd_addr (ram_ctl.rd_addr),
      .rd_data (rd_number)
   );

   // byte sizes, same slots as the numbers
   fbbi_ram #(
      .WIDTH (BYTES_W),
      .DEPTH (MAX_ENTRIES)
   ) u_size_ram (
      .clock   (clock),
      .wr_en   (ram_ctl.wr_en),
      .wr_addr (ram_ctl.wr_addr),
      .wr_data (ram_ctl.wr_bytes),
      .rd_en   (ram_ctl.rd_en),
      .rd_addr (ram_ctl.rd_addr),
      .rd_data (rd_bytes)
   );

   // scan, evict and append sequencer holding the budget and table pointers
   fbbi_core u_core (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_tvalid),
      .req_ready   (req_tready),
      .req_op      (req_tuser),
      .req_number  (req_number),
      .req_bytes   (req_bytes),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .ram_ctl     (ram_ctl),
      .rd_number   (rd_number),
      .rd_bytes    (rd_bytes),
      .res_valid   (res_valid),
      .res_ready   (res_ready),
      .res_data    (res_data)
   );

   // result holding register toward the rsp stream
   fbbi_rsp_reg u_rsp_reg (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (res_valid),
      .in_ready  (res_ready),
      .in_data   (res_data),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (out_data)
   );

   // pack the result fields, lowest first
   assign rsp_tdata = {out_data.total_bytes, out_data.evicted_number};
   assign rsp_tuser = out_data.kind;
   assign rsp_tlast = out_data.last;

endmodule
